// ===== rtl/ksme_pkg.sv =====
// ----------------------------------------------------------------------------
// ksme_pkg
// Shared widths, codes, defaults and word types of the set merge engine.
// ----------------------------------------------------------------------------
package ksme_pkg;

    localparam int CELL_W        = 10;
    localparam int COUNT_W       = 11;
    localparam int MAX_CELLS_DEF = 1024;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [COUNT_W-1:0] CELLS_RESET = 11'd1024;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_EDGE    = 1'b1;

    localparam logic REG_CELLS_IN_USE = 1'b0;

    typedef struct packed {
        logic              req_type;
        logic [CELL_W-1:0] cell_from;
        logic [CELL_W-1:0] cell_to;
    } t_req;

    typedef struct packed {
        logic               joined;
        logic [COUNT_W-1:0] sets_left;
        logic               bad_cell;
    } t_res;

endpackage

// ===== rtl/ksme_if.sv =====
// ----------------------------------------------------------------------------
// ksme_req_if / ksme_rsp_if
// Valid/ready channels carrying request words and result words.
// ----------------------------------------------------------------------------
interface ksme_req_if;
    import ksme_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [CELL_W-1:0] cell_from;
    logic [CELL_W-1:0] cell_to;

    modport source (output valid, output req_type, output cell_from, output cell_to,
                    input ready);
    modport sink   (input valid, input req_type, input cell_from, input cell_to,
                    output ready);
endinterface

interface ksme_rsp_if;
    import ksme_pkg::*;

    logic               valid;
    logic               ready;
    logic               joined;
    logic [COUNT_W-1:0] sets_left;
    logic               bad_cell;

    modport source (output valid, output joined, output sets_left, output bad_cell,
                    input ready);
    modport sink   (input valid, input joined, input sets_left, input bad_cell,
                    output ready);
endinterface

// ===== rtl/ksme_core.sv =====
// ----------------------------------------------------------------------------
// ksme_core
// Label memory with its sequencer: clearing pass, restart pass, label reads
// and the relabeling sweep of a merge.
// ----------------------------------------------------------------------------
module ksme_core #(
    parameter int MAX_CELLS = ksme_pkg::MAX_CELLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [ksme_pkg::COUNT_W-1:0] i_cells,
    input  logic                        i_req_valid,
    input  ksme_pkg::t_req              i_req,
    output logic                        o_req_ready,
    output logic                        o_res_valid,
    output ksme_pkg::t_res              o_res,
    input  logic                        i_res_ready
);
    import ksme_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_CELLS - 1);
    localparam logic [COUNT_W-1:0] COUNT_RST =
        (MAX_CELLS < 1024) ? COUNT_W'(MAX_CELLS) : CELLS_RESET;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_RDA, ST_RDB, ST_SWEEP, ST_DRAIN, ST_INIT, ST_DONE
    } t_state;

    logic [AW-1:0] r_mem [MAX_CELLS];
    logic [AW-1:0] r_rd;

    t_state             r_state;
    logic [AW-1:0]      r_idx;
    logic               r_pend;
    logic [AW-1:0]      r_widx;
    logic [AW-1:0]      r_la;
    logic [AW-1:0]      r_lb;
    logic [AW-1:0]      r_b;
    logic [COUNT_W-1:0] r_count;
    t_res               r_res;

    logic [COUNT_W-1:0] n_active;
    logic               accept;
    logic               bad;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      wdata;

    assign n_active = (32'(i_cells) > MAX_CELLS) ? COUNT_W'(MAX_CELLS) : i_cells;
    assign o_req_ready = (r_state == ST_IDLE);
    assign accept = i_req_valid && o_req_ready;
    assign bad = (COUNT_W'(i_req.cell_from) >= n_active) ||
                 (COUNT_W'(i_req.cell_to) >= n_active);
    assign o_res_valid = (r_state == ST_DONE);
    assign o_res = r_res;

    always_comb begin
        case (r_state)
            ST_IDLE:  raddr = AW'(i_req.cell_from);
            ST_RDA:   raddr = r_b;
            ST_SWEEP: raddr = r_idx;
            default:  raddr = r_idx;
        endcase
        if (r_state == ST_CLEAR || r_state == ST_INIT) begin
            we    = 1'b1;
            waddr = r_idx;
            wdata = r_idx;
        end else begin
            we    = r_pend && (r_rd == r_lb);
            waddr = r_widx;
            wdata = r_la;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_count <= COUNT_RST;
        end else begin
            r_pend <= 1'b0;
            case (r_state)
                ST_CLEAR, ST_INIT: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= (r_state == ST_CLEAR) ? ST_IDLE : ST_DONE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_b <= AW'(i_req.cell_to);
                        if (i_req.req_type == REQ_RESTART) begin
                            r_count <= n_active;
                            r_res   <= '{joined: 1'b0, sets_left: n_active, bad_cell: 1'b0};
                            r_idx   <= '0;
                            r_state <= ST_INIT;
                        end else if (bad) begin
                            r_res   <= '{joined: 1'b0, sets_left: r_count, bad_cell: 1'b1};
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RDA;
                        end
                    end
                end
                ST_RDA: begin
                    r_la    <= r_rd;
                    r_state <= ST_RDB;
                end
                ST_RDB: begin
                    r_lb <= r_rd;
                    if (r_rd != r_la) begin
                        if (r_count != '0) begin
                            r_count <= r_count - 1'b1;
                            r_res   <= '{joined: 1'b1, sets_left: r_count - 1'b1,
                                         bad_cell: 1'b0};
                        end else begin
                            r_res <= '{joined: 1'b1, sets_left: r_count, bad_cell: 1'b0};
                        end
                        r_idx   <= '0;
                        r_state <= ST_SWEEP;
                    end else begin
                        r_res   <= '{joined: 1'b0, sets_left: r_count, bad_cell: 1'b0};
                        r_state <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    r_pend <= 1'b1;
                    r_widx <= r_idx;
                    r_idx  <= r_idx + 1'b1;
                    if (r_idx == LAST_IDX) begin
                        r_idx   <= '0;
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== rtl/kruskal_set_merge_engine.sv =====
// ----------------------------------------------------------------------------
// kruskal_set_merge_engine
// Union-find by relabeling for Kruskal maze generation.
// ----------------------------------------------------------------------------
// Request words arrive on i_req and are accepted when valid and ready are
// both high; each request gives exactly one result word on o_rsp, in order.
// A restart word relabels every cell of the label memory with its own index.
// An edge word reads both labels from the memory; when they differ, a sweep
// reads every entry once and rewrites the matching ones. Out-of-range edges
// finish without a memory read, same-set edges after the two label reads.
// The single memory port pair sets the pace of the sweep: one entry is read
// and at most one written per cycle. After reset the block runs a clearing
// pass over every entry with ready low; the cells_in_use register is at
// address 0 of the APB port and resets to 1024. A finished result waits in
// the output register while the next word is accepted; a stalled receiver
// holds the engine only when a second result is ready behind it.
// ----------------------------------------------------------------------------
module kruskal_set_merge_engine #(
    parameter int MAX_CELLS = ksme_pkg::MAX_CELLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ksme_req_if.sink                       i_req,
    ksme_rsp_if.source                     o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ksme_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [ksme_pkg::APB_DATA_W-1:0] pwdata,
    output logic [ksme_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import ksme_pkg::*;

    logic [COUNT_W-1:0] r_cells;
    logic               r_out_valid;
    t_res               r_out;

    t_req req;
    logic core_res_valid;
    t_res core_res;
    logic core_res_ready;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CELLS_IN_USE) ? APB_DATA_W'(r_cells) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells <= CELLS_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == REG_CELLS_IN_USE) begin
            r_cells <= pwdata[COUNT_W-1:0];
        end
    end

    assign req = '{req_type: i_req.req_type, cell_from: i_req.cell_from,
                   cell_to: i_req.cell_to};
    assign core_res_ready = !r_out_valid || o_rsp.ready;

    ksme_core #(
        .MAX_CELLS (MAX_CELLS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cells     (r_cells),
        .i_req_valid (i_req.valid),
        .i_req       (req),
        .o_req_ready (i_req.ready),
        .o_res_valid (core_res_valid),
        .o_res       (core_res),
        .i_res_ready (core_res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (core_res_valid && core_res_ready) begin
            r_out_valid <= 1'b1;
            r_out       <= core_res;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.joined    = r_out.joined;
    assign o_rsp.sets_left = r_out.sets_left;
    assign o_rsp.bad_cell  = r_out.bad_cell;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Kruskal set merge engine. A local union-find
// copy predicts the result word of every accepted request word, and a
// checker compares each result word against the oldest prediction. Directed
// tests cover reset state, index bounds, a zero register, clamping above the
// cell limit, register changes without restart and the unused register
// slot. A random part then builds shuffled grid mazes of many sizes, mixed
// with stray, repeated and restart words; both channels stall at random but in one round.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ksme_pkg::*;

    localparam int CELLS        = MAX_CELLS_DEF;
    localparam int RANDOM_ITEMS = 530;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int IDLE_PCT     = 12;
    localparam int EDGE_CAP     = 60;

    localparam logic REG_UNUSED = 1'b1;

    typedef struct packed {
        logic [CELL_W-1:0] a;
        logic [CELL_W-1:0] b;
    } t_pair;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ksme_req_if req_ch ();
    ksme_rsp_if rsp_ch ();

    kruskal_set_merge_engine #(
        .MAX_CELLS(CELLS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    logic [CELL_W-1:0]  label_copy [CELLS];
    logic [COUNT_W-1:0] live_sets;
    logic [COUNT_W-1:0] cells_reg;
    t_res               outcome_q [$];
    int                 mismatches  = 0;
    int                 items_sent  = 0;
    int                 words_seen  = 0;
    int                 idle_pct    = IDLE_PCT;
    int                 cycle_count = 0;
    bit                 req_held    = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic void reset_copy();
        int i;
        for (i = 0; i < CELLS; i++) label_copy[i] = CELL_W'(i);
        cells_reg = CELLS_RESET;
        live_sets = (cells_reg > COUNT_W'(CELLS)) ? COUNT_W'(CELLS) : cells_reg;
    endfunction

    function automatic t_res predict_outcome(input t_req w);
        t_res               r;
        logic [COUNT_W-1:0] n;
        logic [CELL_W-1:0]  la;
        logic [CELL_W-1:0]  lb;
        int                 i;
        r = '0;
        n = (cells_reg > COUNT_W'(CELLS)) ? COUNT_W'(CELLS) : cells_reg;
        if (w.req_type == REQ_RESTART) begin
            for (i = 0; i < CELLS; i++) label_copy[i] = CELL_W'(i);
            live_sets = n;
        end else if (COUNT_W'(w.cell_from) >= n || COUNT_W'(w.cell_to) >= n) begin
            r.bad_cell = 1'b1;
        end else begin
            la = label_copy[w.cell_from];
            lb = label_copy[w.cell_to];
            if (la != lb) begin
                for (i = 0; i < CELLS; i++) begin
                    if (label_copy[i] == lb) label_copy[i] = la;
                end
                if (live_sets > 0) live_sets = live_sets - 1'b1;
                r.joined = 1'b1;
            end
        end
        r.sets_left = live_sets;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at word %0d: %s", words_seen, msg);
        mismatches++;
    endtask

    task automatic offer(input logic kind, input logic [CELL_W-1:0] a,
                         input logic [CELL_W-1:0] b);
        t_req w;
        w.req_type  = kind;
        w.cell_from = a;
        w.cell_to   = b;
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.cell_from <= a;
        req_ch.cell_to   <= b;
        req_held = 1'b1;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        outcome_q.insert(outcome_q.size(), predict_outcome(w));
        items_sent++;
        if ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 40);
        end
    endtask

    task automatic edge_word(input int a, input int b);
        offer(REQ_EDGE, CELL_W'(a), CELL_W'(b));
    endtask

    task automatic restart_word();
        offer(REQ_RESTART, CELL_W'($urandom), CELL_W'($urandom));
    endtask

    task automatic quiet_sender();
        if (req_held) begin
            req_ch.valid <= 1'b0;
            req_held = 1'b0;
        end
        @(posedge i_clk);
    endtask

    task automatic await_outcomes();
        quiet_sender();
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic index, input logic [APB_DATA_W-1:0] value);
        logic [APB_ADDR_W-1:0] addr;
        addr = {index, 2'b00};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (index == REG_CELLS_IN_USE) cells_reg = value[COUNT_W-1:0];
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (index == REG_CELLS_IN_USE && prdata !== APB_DATA_W'(cells_reg)) begin
            flag_mismatch($sformatf("register read %0d want %0d", prdata, cells_reg));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        t_res exp_w;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
                words_seen++;
                if (outcome_q.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    exp_w = outcome_q[0];
                    outcome_q.delete(0);
                    if (rsp_ch.joined !== exp_w.joined)
                        flag_mismatch($sformatf("joined %0b want %0b",
                                                rsp_ch.joined, exp_w.joined));
                    if (rsp_ch.sets_left !== exp_w.sets_left)
                        flag_mismatch($sformatf("sets_left %0d want %0d",
                                                rsp_ch.sets_left, exp_w.sets_left));
                    if (rsp_ch.bad_cell !== exp_w.bad_cell)
                        flag_mismatch($sformatf("bad_cell %0b want %0b",
                                                rsp_ch.bad_cell, exp_w.bad_cell));
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic test_after_reset();
        edge_word(0, 1023);
        edge_word(1023, 0);
        edge_word(1023, 1023);
        edge_word(512, 511);
        edge_word(341, 682);
        edge_word(682, 0);
        restart_word();
        edge_word(1023, 0);
    endtask

    task automatic test_bounds();
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 8);
        restart_word();
        edge_word(7, 0);
        edge_word(8, 0);
        edge_word(0, 8);
        edge_word(1023, 1023);
        edge_word(3, 3);
    endtask

    task automatic test_zero_register();
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 0);
        restart_word();
        edge_word(0, 0);
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 1);
        restart_word();
        edge_word(0, 0);
        edge_word(0, 1);
    endtask

    task automatic test_above_limit();
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 2047);
        restart_word();
        edge_word(1023, 1022);
    endtask

    task automatic test_change_without_restart();
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 1024);
        restart_word();
        edge_word(2, 700);
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 4);
        edge_word(0, 5);
        edge_word(2, 3);
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 2);
        restart_word();
        await_outcomes();
        write_register(REG_CELLS_IN_USE, 1024);
        edge_word(10, 11);
        edge_word(12, 13);
        edge_word(14, 15);
    endtask

    task automatic test_unused_register();
        await_outcomes();
        write_register(REG_UNUSED, 3);
        edge_word(20, 21);
        edge_word(5, 1000);
    endtask

    task automatic test_random_mazes();
        t_pair             grid_edges [$];
        t_pair             tmp;
        int                goal;
        int                phase;
        int                rows;
        int                cols;
        int                budget;
        int                roll;
        int                j;
        int                k;
        logic [COUNT_W-1:0] reg_val;
        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal) begin
            await_outcomes();
            idle_pct = (phase == 3) ? 0 : IDLE_PCT;
            roll = (phase == 3) ? 0 : $urandom_range(99);
            rows = $urandom_range(8, 1);
            cols = $urandom_range(8, 1);
            reg_val = COUNT_W'(rows * cols);
            if (roll < 8) begin
                rows = 32;
                cols = 32;
                reg_val = COUNT_W'(1024);
            end else if (roll < 12) begin
                rows = 32;
                cols = 32;
                reg_val = COUNT_W'($urandom_range(2047, 1025));
            end else if (roll < 15) begin
                reg_val = '0;
            end
            write_register(REG_CELLS_IN_USE, APB_DATA_W'(reg_val));
            restart_word();
            grid_edges.delete();
            for (j = 0; j < rows; j++) begin
                for (k = 0; k < cols; k++) begin
                    if (k + 1 < cols) grid_edges.insert(grid_edges.size(),
                                                        {CELL_W'(j * cols + k),
                                                         CELL_W'(j * cols + k + 1)});
                    if (j + 1 < rows) grid_edges.insert(grid_edges.size(),
                                                        {CELL_W'(j * cols + k),
                                                         CELL_W'((j + 1) * cols + k)});
                end
            end
            for (j = grid_edges.size() - 1; j > 0; j--) begin
                k = $urandom_range(j, 0);
                tmp = grid_edges[j];
                grid_edges[j] = grid_edges[k];
                grid_edges[k] = tmp;
            end
            budget = (grid_edges.size() < EDGE_CAP) ? grid_edges.size() : EDGE_CAP;
            if (reg_val == 0 || budget == 0) budget = 6;
            for (j = 0; j < budget; j++) begin
                roll = $urandom_range(99);
                if (roll < 6 || grid_edges.size() == 0) begin
                    edge_word($urandom_range(1023), $urandom_range(1023));
                end else if (roll < 10) begin
                    tmp = grid_edges[$urandom_range(j < grid_edges.size() ? j : 0, 0)];
                    edge_word(tmp.b, tmp.a);
                end else if (roll < 12) begin
                    restart_word();
                end else begin
                    tmp = grid_edges[j % grid_edges.size()];
                    if ($urandom_range(1)) edge_word(tmp.a, tmp.b);
                    else edge_word(tmp.b, tmp.a);
                end
            end
            phase++;
        end
        idle_pct = IDLE_PCT;
    endtask

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_RESTART;
        req_ch.cell_from = '0;
        req_ch.cell_to   = '0;
        reset_copy();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_bounds();
        test_zero_register();
        test_above_limit();
        test_change_without_restart();
        test_unused_register();
        test_random_mazes();
        quiet_sender();
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (CELLS + 16) @(posedge i_clk);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
